>>> hdl/tcch_pkg.sv
// Package for the tilt-compensated compass heading unit.
// Holds widths, the degree-scaled arctangent table and shared types. No dependencies.
package tcch_pkg;

  localparam int SampleW   = 16;
  localparam int RefW      = 16;
  localparam int HeadW     = 15;
  localparam int FracBits  = 6;
  localparam int AngFrac   = 20;
  localparam int Steps     = 16;
  localparam int CrossW    = 2 * SampleW + 2;
  localparam int RedW      = 16;
  localparam int NW        = 34;
  localparam int DotW      = 52;
  localparam int LenW      = 16;
  localparam int CordW     = 72;
  localparam int AngW      = 32;
  localparam int AddrW     = 2;

  localparam logic [AddrW-1:0] RegRefX = 2'd0;
  localparam logic [AddrW-1:0] RegRefY = 2'd1;
  localparam logic [AddrW-1:0] RegRefZ = 2'd2;

  typedef logic signed [RedW-1:0] red_vec_t [3];

  typedef struct packed {
    logic valid;
    logic degen;
  } tcch_ctl_t;

  function automatic logic signed [AngW-1:0] atan_deg(input int i);
    logic signed [AngW-1:0] t;
    case (i)
      0: t = 32'sd47185920;  1: t = 32'sd27855475;  2: t = 32'sd14718068;
      3: t = 32'sd7471121;   4: t = 32'sd3750058;   5: t = 32'sd1876857;
      6: t = 32'sd938658;    7: t = 32'sd469357;    8: t = 32'sd234682;
      9: t = 32'sd117342;    10: t = 32'sd58671;    11: t = 32'sd29335;
      12: t = 32'sd14668;    13: t = 32'sd7334;     14: t = 32'sd3667;
      15: t = 32'sd1833;     16: t = 32'sd917;      17: t = 32'sd458;
      18: t = 32'sd229;      19: t = 32'sd115;      20: t = 32'sd57;
      21: t = 32'sd29;       22: t = 32'sd14;       23: t = 32'sd7;
      default: t = '0;
    endcase
    return t;
  endfunction

  // Shift of the smallest floor right shift bringing max |v| below 2^15.
  function automatic logic [5:0] red_shift(input logic signed [CrossW-1:0] v0,
                                            input logic signed [CrossW-1:0] v1,
                                            input logic signed [CrossW-1:0] v2);
    logic [CrossW-1:0] a0, a1, a2, mx;
    logic [5:0] s;
    a0 = v0[CrossW-1] ? CrossW'(-v0) : CrossW'(v0);
    a1 = v1[CrossW-1] ? CrossW'(-v1) : CrossW'(v1);
    a2 = v2[CrossW-1] ? CrossW'(-v2) : CrossW'(v2);
    mx = a0;
    if (a1 > mx) mx = a1;
    if (a2 > mx) mx = a2;
    s = '0;
    for (int b = 15; b < CrossW; b++) begin
      if (mx[b]) s = 6'(b - 14);
    end
    return s;
  endfunction

endpackage

>>> hdl/tilt_compensated_compass_heading_unit.sv
// Tilt-compensated compass heading: front, square root, CORDIC and output
// stages; one request per cycle is taken while the output is not stalled.
// The whole pipe advances when the output is empty or not stalled; in_stall
// mirrors that, so a stalled result holds and nothing is lost or repeated.
// Synchronous active-low reset clears valid bits and sets ref to (1,0,0).
module tilt_compensated_compass_heading_unit import tcch_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [SampleW-1:0] in_accel_x,
  input  logic signed [SampleW-1:0] in_accel_y,
  input  logic signed [SampleW-1:0] in_accel_z,
  input  logic signed [SampleW-1:0] in_mag_x,
  input  logic signed [SampleW-1:0] in_mag_y,
  input  logic signed [SampleW-1:0] in_mag_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [HeadW-1:0]          out_heading,
  output logic                      out_degenerate,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [AddrW-1:0]          cfg_index,
  input  logic [RefW-1:0]           cfg_data
);

  logic signed [RefW-1:0] ref_x_r, ref_y_r, ref_z_r;
  logic adv;
  tcch_ctl_t c_in, c_f, c_s;
  logic signed [DotW-1:0] ed_f, nd_f, ed_s, nd_s;
  logic [LenW*2+2-1:0] sq_f;
  logic [LenW:0] root;

  // global enable: pipe moves unless a held result is stalled
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign cfg_ready = 1'b1;
  assign c_in = '{valid: in_valid, degen: 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_x_r <= 16'sd1; ref_y_r <= '0; ref_z_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegRefX: ref_x_r <= cfg_data;
        RegRefY: ref_y_r <= cfg_data;
        RegRefZ: ref_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tcch_front u_front (
    .clk, .rst_n, .adv, .ctl_in(c_in),
    .ax(in_accel_x), .ay(in_accel_y), .az(in_accel_z),
    .mx(in_mag_x), .my(in_mag_y), .mz(in_mag_z),
    .rx(ref_x_r), .ry(ref_y_r), .rz(ref_z_r),
    .ctl_out(c_f), .e_dot(ed_f), .n_dot(nd_f), .len_sq(sq_f)
  );

  tcch_sqrt u_sqrt (
    .clk, .rst_n, .adv, .ctl_in(c_f), .e_in(ed_f), .n_in(nd_f), .sq_in(sq_f),
    .ctl_out(c_s), .e_out(ed_s), .n_out(nd_s), .root
  );

  tcch_cordic u_cordic (
    .clk, .rst_n, .adv, .ctl_in(c_s), .e_in(ed_s), .n_in(nd_s), .root,
    .vld(out_valid), .degen(out_degenerate), .heading(out_heading)
  );

endmodule

>>> hdl/tcch_front.sv
// Front stages: east cross product, vector reduction, north cross product,
// dot products and the squared length of the reduced accel. Uses tcch_pkg.
module tcch_front import tcch_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  tcch_ctl_t                ctl_in,
  input  logic signed [SampleW-1:0] ax, ay, az, mx, my, mz,
  input  logic signed [RefW-1:0]   rx, ry, rz,
  output tcch_ctl_t                ctl_out,
  output logic signed [DotW-1:0]   e_dot,
  output logic signed [DotW-1:0]   n_dot,
  output logic [LenW*2+2-1:0]      len_sq
);

  // stage 1: east = m x a
  tcch_ctl_t c1_r;
  logic signed [CrossW-1:0] e1_r [3];
  logic signed [SampleW-1:0] a1_r [3];
  // stage 2: reduced vectors
  tcch_ctl_t c2_r;
  red_vec_t a2_r, e2_r;
  // stage 3: north and partial products
  tcch_ctl_t c3_r;
  logic signed [NW-1:0] n3_r [3];
  logic signed [DotW-1:0] ed3_r;
  logic [LenW*2+2-1:0] sq3_r;
  // stage 4: dots
  tcch_ctl_t c4_r;
  logic signed [DotW-1:0] ed4_r, nd4_r;
  logic [LenW*2+2-1:0] sq4_r;

  logic [5:0] sa, se;
  logic signed [CrossW-1:0] ae [3];
  logic signed [NW-1:0] nn [3];

  always_comb begin
    ae[0] = CrossW'(a1_r[0]);
    ae[1] = CrossW'(a1_r[1]);
    ae[2] = CrossW'(a1_r[2]);
    sa = red_shift(ae[0], ae[1], ae[2]);
    se = red_shift(e1_r[0], e1_r[1], e1_r[2]);
    nn[0] = NW'(a2_r[1]) * NW'(e2_r[2]) - NW'(a2_r[2]) * NW'(e2_r[1]);
    nn[1] = NW'(a2_r[2]) * NW'(e2_r[0]) - NW'(a2_r[0]) * NW'(e2_r[2]);
    nn[2] = NW'(a2_r[0]) * NW'(e2_r[1]) - NW'(a2_r[1]) * NW'(e2_r[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0; c2_r <= '0; c3_r <= '0; c4_r <= '0;
    end else if (adv) begin
      c1_r <= ctl_in;
      c2_r <= '{valid: c1_r.valid,
                degen: (e1_r[0] == 0) && (e1_r[1] == 0) && (e1_r[2] == 0)};
      c3_r <= c2_r; c4_r <= c3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_r[0] <= CrossW'(my) * CrossW'(az) - CrossW'(mz) * CrossW'(ay);
      e1_r[1] <= CrossW'(mz) * CrossW'(ax) - CrossW'(mx) * CrossW'(az);
      e1_r[2] <= CrossW'(mx) * CrossW'(ay) - CrossW'(my) * CrossW'(ax);
      a1_r[0] <= ax; a1_r[1] <= ay; a1_r[2] <= az;
      for (int k = 0; k < 3; k++) begin
        a2_r[k] <= RedW'(ae[k] >>> sa);
        e2_r[k] <= RedW'(e1_r[k] >>> se);
      end
      for (int k = 0; k < 3; k++) n3_r[k] <= nn[k];
      ed3_r <= DotW'(e2_r[0]) * DotW'(rx) + DotW'(e2_r[1]) * DotW'(ry)
             + DotW'(e2_r[2]) * DotW'(rz);
      sq3_r <= (LenW*2+2)'(a2_r[0]) * (LenW*2+2)'(a2_r[0])
             + (LenW*2+2)'(a2_r[1]) * (LenW*2+2)'(a2_r[1])
             + (LenW*2+2)'(a2_r[2]) * (LenW*2+2)'(a2_r[2]);
      ed4_r <= ed3_r;
      nd4_r <= DotW'(n3_r[0]) * DotW'(rx) + DotW'(n3_r[1]) * DotW'(ry)
             + DotW'(n3_r[2]) * DotW'(rz);
      sq4_r <= sq3_r;
    end
  end

  assign ctl_out = c4_r;
  assign e_dot   = ed4_r;
  assign n_dot   = nd4_r;
  assign len_sq  = sq4_r;

endmodule

>>> hdl/tcch_sqrt.sv
// Pipelined integer square root, one result bit per stage, with the east and
// north dots carried alongside. Uses tcch_pkg.
module tcch_sqrt import tcch_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  tcch_ctl_t              ctl_in,
  input  logic signed [DotW-1:0] e_in,
  input  logic signed [DotW-1:0] n_in,
  input  logic [LenW*2+2-1:0]    sq_in,
  output tcch_ctl_t              ctl_out,
  output logic signed [DotW-1:0] e_out,
  output logic signed [DotW-1:0] n_out,
  output logic [LenW:0]          root
);
  localparam int Bits = LenW + 1;
  localparam int RemW = 2 * Bits + 2;

  tcch_ctl_t c_r [Bits];
  logic signed [DotW-1:0] e_r [Bits], n_r [Bits];
  logic [RemW-1:0] rem_r [Bits];
  logic [Bits-1:0] q_r [Bits];
  logic [RemW-1:0] rem_n [Bits];
  logic [Bits-1:0] q_n [Bits];

  // restoring root: stage k decides bit Bits-1-k
  always_comb begin
    for (int k = 0; k < Bits; k++) begin
      logic [RemW-1:0] rin, trial;
      logic [Bits-1:0] qin;
      rin = (k == 0) ? RemW'(sq_in) : rem_r[k-1];
      qin = (k == 0) ? '0 : q_r[k-1];
      trial = (RemW'(qin) << (Bits - k)) | (RemW'(1) << (2 * (Bits - 1 - k)));
      if (rin >= trial) begin
        rem_n[k] = rin - trial;
        q_n[k] = qin | (Bits'(1) << (Bits - 1 - k));
      end else begin
        rem_n[k] = rin;
        q_n[k] = qin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < Bits; k++) c_r[k] <= '0;
    end else if (adv) begin
      c_r[0] <= ctl_in;
      for (int k = 1; k < Bits; k++) c_r[k] <= c_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < Bits; k++) begin
        rem_r[k] <= rem_n[k];
        q_r[k] <= q_n[k];
        e_r[k] <= (k == 0) ? e_in : e_r[k-1];
        n_r[k] <= (k == 0) ? n_in : n_r[k-1];
      end
    end
  end

  assign ctl_out = c_r[Bits-1];
  assign e_out = e_r[Bits-1];
  assign n_out = n_r[Bits-1];
  assign root = q_r[Bits-1];

endmodule

>>> hdl/tcch_cordic.sv
// CORDIC vectoring pipeline: scales east by the length, folds the left half
// plane, runs one rotation per stage and rounds to the heading. Uses tcch_pkg.
module tcch_cordic import tcch_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  tcch_ctl_t              ctl_in,
  input  logic signed [DotW-1:0] e_in,
  input  logic signed [DotW-1:0] n_in,
  input  logic [LenW:0]          root,
  output logic                   vld,
  output logic                   degen,
  output logic [HeadW-1:0]       heading
);
  localparam int Full = 360 << AngFrac;
  localparam int HFull = 360 << FracBits;
  localparam int Sh = AngFrac - FracBits;

  // stage A: y = E*len (cut into two 26x17 partial products)
  tcch_ctl_t ca_r;
  logic signed [CordW-1:0] pa_hi_r, pa_lo_r, xa_r;
  // stage B: fold
  tcch_ctl_t cb_r;
  logic zero_b_r;
  logic signed [CordW-1:0] xb_r, yb_r;
  logic signed [AngW-1:0] zb_r;
  // rotations
  tcch_ctl_t cs_r [Steps];
  logic zs_r [Steps];
  logic signed [CordW-1:0] xs_r [Steps], ys_r [Steps];
  logic signed [AngW-1:0] as_r [Steps];
  // output
  logic vo_r, do_r;
  logic [HeadW-1:0] ho_r;

  logic signed [CordW-1:0] y_full, xs_n [Steps], ys_n [Steps];
  logic signed [AngW-1:0] as_n [Steps];
  logic signed [AngW:0] zf;
  logic [AngW:0] hr;
  logic [AngW-Sh:0] hq;

  assign y_full = pa_hi_r + pa_lo_r;

  always_comb begin
    for (int i = 0; i < Steps; i++) begin
      logic signed [CordW-1:0] xi, yi;
      logic signed [AngW-1:0] zi;
      xi = (i == 0) ? xb_r : xs_r[i-1];
      yi = (i == 0) ? yb_r : ys_r[i-1];
      zi = (i == 0) ? zb_r : as_r[i-1];
      if (!yi[CordW-1]) begin
        xs_n[i] = xi + (yi >>> i);
        ys_n[i] = yi - (xi >>> i);
        as_n[i] = zi + atan_deg(i);
      end else begin
        xs_n[i] = xi - (yi >>> i);
        ys_n[i] = yi + (xi >>> i);
        as_n[i] = zi - atan_deg(i);
      end
    end
    zf = (AngW+1)'(as_r[Steps-1]);
    if (zf < 0) zf = zf + (AngW+1)'(Full);
    hr = (AngW+1)'(zf) + ((AngW+1)'(1) << (Sh - 1));
    hq = (AngW-Sh+1)'(hr >> Sh);
    if (hq >= (AngW-Sh+1)'(HFull)) hq = hq - (AngW-Sh+1)'(HFull);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_r <= '0; cb_r <= '0; vo_r <= 1'b0;
      for (int i = 0; i < Steps; i++) cs_r[i] <= '0;
    end else if (adv) begin
      ca_r <= ctl_in; cb_r <= ca_r; cs_r[0] <= cb_r;
      for (int i = 1; i < Steps; i++) cs_r[i] <= cs_r[i-1];
      vo_r <= cs_r[Steps-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_hi_r <= CordW'(e_in >>> 26) * CordW'({1'b0, root}) <<< 26;
      pa_lo_r <= CordW'({1'b0, e_in[25:0]}) * CordW'({1'b0, root});
      xa_r <= CordW'(n_in);
      zero_b_r <= (xa_r == 0) && (y_full == 0);
      if (xa_r < 0) begin
        xb_r <= -xa_r; yb_r <= -y_full; zb_r <= AngW'(180 << AngFrac);
      end else begin
        xb_r <= xa_r; yb_r <= y_full; zb_r <= '0;
      end
      for (int i = 0; i < Steps; i++) begin
        xs_r[i] <= xs_n[i]; ys_r[i] <= ys_n[i]; as_r[i] <= as_n[i];
        zs_r[i] <= (i == 0) ? zero_b_r : zs_r[i-1];
      end
      do_r <= cs_r[Steps-1].degen;
      ho_r <= (cs_r[Steps-1].degen || zs_r[Steps-1]) ? '0 : HeadW'(hq);
    end
  end

  assign vld = vo_r;
  assign degen = do_r;
  assign heading = ho_r;

endmodule

>>> hdl/tcch_checker.sv
// Port-level checker for the compass heading unit, bound to the top level.
// Uses tcch_pkg for widths.
module tcch_checker import tcch_pkg::*; (
  input logic clk, rst_n, in_stall, out_valid, out_stall, out_degenerate,
  input logic [HeadW-1:0] out_heading
);
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_heading < HeadW'(360 << FracBits)) else $error("heading range");
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_heading == '0) else $error("degenerate heading");
  a_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall)) else $error("input stall mismatch");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_heading)) else $error("held result");
endmodule

bind tilt_compensated_compass_heading_unit tcch_checker u_chk (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_degenerate, .out_heading
);
